### hw/rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, widths and constants of the prefetch training table.
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;

   localparam int PC_W     = 64;
   localparam int LINE_W   = 58;
   localparam int CRIT_W   = 32;
   localparam int STAMP_W  = 48;
   localparam int CONF_W   = 16;
   localparam int DIST_W   = 19;
   localparam int WAIT_W   = 9;
   localparam int REUSE_W  = 6;
   localparam int ACTION_W = 2;
   localparam int MODE_W   = 2;

   localparam int REQ_DATA_W = 208;
   localparam int RSP_DATA_W = 120;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DIV_STEPS = 32;
   localparam int DIVISOR_W = CRIT_W + 1;

   localparam logic [CRIT_W-1:0]  LIMIT_BIAS     = CRIT_W'(100);
   localparam logic [DIST_W:0]    REUSE_LIMIT    = (DIST_W+1)'(1024);
   localparam logic [REUSE_W-1:0] REUSE_CONF_MAX = REUSE_W'(32);
   localparam logic [WAIT_W-1:0]  WAIT_TIMEOUT   = WAIT_W'(256);
   localparam logic [DIST_W-1:0]  DIST_TIMEOUT   = DIST_W'(262144);

   localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd3;

   localparam logic FUNC_REFILL = 1'b0;
   localparam logic FUNC_ACCESS = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CRIT_MODE   = 3'd0,
      CSR_CONF_THR    = 3'd1,
      CSR_CONF_MAX    = 3'd2,
      CSR_CRIT_LIMIT  = 3'd3,
      CSR_PAT_EN      = 3'd4,
      CSR_PAT_DYN_EN  = 3'd5
   } csr_idx_type;

   typedef enum logic {
      PH_SCAN = 1'b0,
      PH_RANK = 1'b1
   } phase_type;

   typedef struct packed {
      logic      load;
      logic      rd;
      phase_type phase;
      logic      sel_match;
      logic      div_start;
      logic      update;
      logic      alloc;
      logic      emit;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic is_access;
      logic full;
      logic div_busy;
   } sts_type;

   typedef struct packed {
      logic [LINE_W-1:0]  prev_line;
      logic [CONF_W-1:0]  crit_conf;
      logic [LINE_W-1:0]  first_line;
      logic [LINE_W-1:0]  second_line;
      logic [DIST_W-1:0]  dist_cnt;
      logic [WAIT_W-1:0]  wait_ctr;
      logic [REUSE_W-1:0] reuse_conf;
   } ent_type;

endpackage

### hw/rtl/prefetch_training_table.sv
// ----------------------------------------------------------------------------
// prefetch_training_table
// Fully associative training table of a temporal prefetcher.
// ----------------------------------------------------------------------------
// Input transactions arrive on req_*: tuser selects refill (0) or demand
// access (1); tdata carries the instruction address, line address, hit flag,
// criticality and stamp. Each transaction yields exactly one result on rsp_*.
// The user writes registers through csr_* only while no transaction is
// in flight; the block does not enforce this. One transaction is worked
// on at a time. Every transaction searches the table one entry per cycle
// through the tag, stamp and rank memories, then decides and goes on with:
//   access to a known entry        entry read and update
//   refill of a known entry        restoring divider, entry read and update
//   allocation, table not full     entry written at the next free slot
//   allocation, table full         rank renumbering pass, victim replaced
// and last hands the result to the output register. The next
// transaction is accepted while a result waits there; a stalled receiver
// holds the block at the hand-off only once a second result is ready.
// Reset empties the table through its fill count and loads register defaults.
// ----------------------------------------------------------------------------
module prefetch_training_table #(
   parameter int TABLE_ENTRIES = ptt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pc[63:0], line_addr[121:64], hit[122], crit_value[154:123],
   // stamp[202:155], zero fill
   input  logic [ptt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // meta_action[1:0], trig_line[59:2], target_addr[117:60],
   // miss_sample[118], zero fill
   output logic [ptt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [ptt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ptt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   ptt_pkg::cmd_type  cmd;
   ptt_pkg::sts_type  sts;
   logic [AW-1:0]     addr;

   ptt_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .AW            (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd),
      .addr       (addr)
   );

   ptt_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .AW            (AW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .addr      (addr),
      .sts       (sts),
      .req_func  (req_tuser),
      .req_pc    (req_tdata[63:0]),
      .req_line  (req_tdata[121:64]),
      .req_hit   (req_tdata[122]),
      .req_crit  (req_tdata[154:123]),
      .req_stamp (req_tdata[202:155]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_tdata)
   );

`ifndef SYNTH
   // one transaction at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction accepted while one is in flight");

   // a result is only handed over when the output register is free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrote a pending result");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("handed-over result not presented");

   // the divider only runs inside a transaction
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      sts.div_busy |-> !req_tready)
      else $error("divider busy while idle");
`endif

endmodule

### hw/rtl/ptt_div.sv
// ----------------------------------------------------------------------------
// ptt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptt_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ptt_pkg::CRIT_W-1:0]     dividend,
   input  logic [ptt_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           busy,
   output logic [ptt_pkg::CRIT_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(ptt_pkg::DIV_STEPS);

   logic                            busy_ff, busy_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [ptt_pkg::DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [ptt_pkg::CRIT_W-1:0]      quo_ff, quo_in;
   logic [ptt_pkg::DIVISOR_W:0]     shifted;
   logic [ptt_pkg::DIVISOR_W:0]     diff;
   logic                            ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[ptt_pkg::CRIT_W-1]};
      ge      = shifted >= {1'b0, divisor};
      diff    = shifted - {1'b0, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[ptt_pkg::DIVISOR_W-1:0] : shifted[ptt_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[ptt_pkg::CRIT_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ptt_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### hw/rtl/ptt_dpath.sv
// ----------------------------------------------------------------------------
// ptt_dpath
// Table memories, search and victim tracking, entry update and result register.
// ----------------------------------------------------------------------------
module ptt_dpath #(
   parameter int TABLE_ENTRIES = ptt_pkg::TABLE_ENTRIES_DEF,
   parameter int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ptt_pkg::cmd_type                 cmd,
   input  logic [AW-1:0]                    addr,
   output ptt_pkg::sts_type                 sts,
   input  logic                             req_func,
   input  logic [ptt_pkg::PC_W-1:0]         req_pc,
   input  logic [ptt_pkg::LINE_W-1:0]       req_line,
   input  logic                             req_hit,
   input  logic [ptt_pkg::CRIT_W-1:0]       req_crit,
   input  logic [ptt_pkg::STAMP_W-1:0]      req_stamp,
   input  logic                             csr_we,
   input  logic [ptt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ptt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic [ptt_pkg::RSP_DATA_W-1:0]   rsp_data
);

   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   // configuration
   logic [ptt_pkg::MODE_W-1:0] mode_ff;
   logic [ptt_pkg::CONF_W-1:0] thr_ff;
   logic [ptt_pkg::CONF_W-1:0] cmax_ff;
   logic [ptt_pkg::CRIT_W-1:0] limit_ff;
   logic                       pen_ff;
   logic                       pdyn_ff;

   // latched transaction
   logic                        func_ff;
   logic [ptt_pkg::PC_W-1:0]    pc_ff;
   logic [ptt_pkg::LINE_W-1:0]  line_ff;
   logic                        hit_ff;
   logic [ptt_pkg::CRIT_W-1:0]  crit_ff;
   logic [ptt_pkg::STAMP_W-1:0] stamp_ff;

   // table memories
   logic [ptt_pkg::PC_W-1:0]    pc_mem   [TABLE_ENTRIES];
   logic [ptt_pkg::STAMP_W-1:0] rec_mem  [TABLE_ENTRIES];
   logic [AW-1:0]               rank_mem [TABLE_ENTRIES];
   ptt_pkg::ent_type            ent_mem  [TABLE_ENTRIES];

   logic [ptt_pkg::PC_W-1:0]    pc_q;
   logic [ptt_pkg::STAMP_W-1:0] rec_q;
   logic [AW-1:0]               rank_q;
   ptt_pkg::ent_type            ent_q;

   logic                        rdv_ff;
   ptt_pkg::phase_type          phase_ff;
   logic [AW-1:0]               addr_q_ff;
   logic [AW-1:0]               rd_addr;

   logic [CW-1:0]               used_ff, used_in;

   // search results
   logic                        match_ff, match_in;
   logic [AW-1:0]               midx_ff, midx_in;
   logic                        found_ff, found_in;
   logic [ptt_pkg::STAMP_W-1:0] best_rec_ff, best_rec_in;
   logic [AW-1:0]               best_rank_ff, best_rank_in;
   logic [AW-1:0]               best_idx_ff, best_idx_in;
   logic [AW-1:0]               r0_idx_ff, r0_idx_in;

   logic                        entry_live;
   logic                        full;
   logic [AW-1:0]               vic_idx;
   logic [AW-1:0]               vic_rank;
   logic [AW-1:0]               alloc_idx;
   logic [AW-1:0]               alloc_rank;
   logic                        rank_wr;

   // result
   logic [ptt_pkg::ACTION_W-1:0] act_ff, act_in;
   logic [ptt_pkg::LINE_W-1:0]   trig_ff, trig_in;
   logic [ptt_pkg::LINE_W-1:0]   tgt_ff, tgt_in;
   logic                         miss_ff, miss_in;
   logic [ptt_pkg::RSP_DATA_W-1:0] rsp_ff;

   // entry update
   ptt_pkg::ent_type             ent_new;
   ptt_pkg::ent_type             ent_alloc;
   logic                         div_busy;
   logic [ptt_pkg::CRIT_W-1:0]   quo;
   logic [ptt_pkg::CRIT_W+1:0]   raised;
   logic [ptt_pkg::DIST_W:0]     reuse_span;
   logic                         critical;
   logic                         gate;

   ptt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (crit_ff),
      .divisor  ({1'b0, limit_ff} + {1'b0, ptt_pkg::LIMIT_BIAS}),
      .busy     (div_busy),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ptt_pkg::MODE_W'(1);
         thr_ff   <= ptt_pkg::CONF_W'(4);
         cmax_ff  <= ptt_pkg::CONF_W'(8);
         limit_ff <= '0;
         pen_ff   <= 1'b0;
         pdyn_ff  <= 1'b0;
      end else if (csr_we) begin
         case (ptt_pkg::csr_idx_type'(csr_index))
            ptt_pkg::CSR_CRIT_MODE:  mode_ff  <= csr_wdata[ptt_pkg::MODE_W-1:0];
            ptt_pkg::CSR_CONF_THR:   thr_ff   <= csr_wdata[ptt_pkg::CONF_W-1:0];
            ptt_pkg::CSR_CONF_MAX:   cmax_ff  <= csr_wdata[ptt_pkg::CONF_W-1:0];
            ptt_pkg::CSR_CRIT_LIMIT: limit_ff <= csr_wdata[ptt_pkg::CRIT_W-1:0];
            ptt_pkg::CSR_PAT_EN:     pen_ff   <= csr_wdata[0];
            ptt_pkg::CSR_PAT_DYN_EN: pdyn_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         pc_ff    <= req_pc;
         line_ff  <= req_line;
         hit_ff   <= req_hit;
         crit_ff  <= req_crit;
         stamp_ff <= req_stamp;
      end
   end

   // ---------------------------------------------------------------- search
   always_comb begin
      rd_addr    = cmd.sel_match ? midx_ff : addr;
      entry_live = CW'(addr_q_ff) < used_ff;
      full       = used_ff == CW'(TABLE_ENTRIES);
      vic_idx    = found_ff ? best_idx_ff  : r0_idx_ff;
      vic_rank   = found_ff ? best_rank_ff : '0;
      alloc_idx  = full ? vic_idx : used_ff[AW-1:0];
      alloc_rank = full ? AW'(used_ff - 1'b1) : used_ff[AW-1:0];
      rank_wr    = rdv_ff && (phase_ff == ptt_pkg::PH_RANK) && entry_live &&
                   (rank_q > vic_rank);

      match_in     = match_ff;
      midx_in      = midx_ff;
      found_in     = found_ff;
      best_rec_in  = best_rec_ff;
      best_rank_in = best_rank_ff;
      best_idx_in  = best_idx_ff;
      r0_idx_in    = r0_idx_ff;
      if (cmd.load) begin
         match_in = 1'b0;
         found_in = 1'b0;
      end else if (rdv_ff && (phase_ff == ptt_pkg::PH_SCAN) && entry_live) begin
         if (pc_q == pc_ff) begin
            match_in = 1'b1;
            midx_in  = addr_q_ff;
         end
         if (rank_q == '0) begin
            r0_idx_in = addr_q_ff;
         end
         // oldest stamp strictly below the current one, earliest insertion on ties
         if ((rec_q < stamp_ff) && (!found_ff || (rec_q < best_rec_ff) ||
             ((rec_q == best_rec_ff) && (rank_q < best_rank_ff)))) begin
            found_in     = 1'b1;
            best_rec_in  = rec_q;
            best_rank_in = rank_q;
            best_idx_in  = addr_q_ff;
         end
      end

      used_in = used_ff;
      if (cmd.alloc && !full) begin
         used_in = used_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff   <= 1'b0;
         used_ff  <= '0;
         match_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         rdv_ff   <= cmd.rd;
         used_ff  <= used_in;
         match_ff <= match_in;
         found_ff <= found_in;
      end
      phase_ff     <= cmd.phase;
      addr_q_ff    <= rd_addr;
      midx_ff      <= midx_in;
      best_rec_ff  <= best_rec_in;
      best_rank_ff <= best_rank_in;
      best_idx_ff  <= best_idx_in;
      r0_idx_ff    <= r0_idx_in;
   end

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         pc_mem[alloc_idx] <= pc_ff;
      end
      if (cmd.rd) begin
         pc_q <= pc_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         rec_mem[alloc_idx] <= stamp_ff;
      end else if (cmd.update && func_ff) begin
         rec_mem[midx_ff] <= stamp_ff;
      end
      if (cmd.rd) begin
         rec_q <= rec_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         rank_mem[alloc_idx] <= alloc_rank;
      end else if (rank_wr) begin
         rank_mem[addr_q_ff] <= rank_q - 1'b1;
      end
      if (cmd.rd) begin
         rank_q <= rank_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         ent_mem[alloc_idx] <= ent_alloc;
      end else if (cmd.update) begin
         ent_mem[midx_ff] <= ent_new;
      end
      if (cmd.rd) begin
         ent_q <= ent_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------- update
   always_comb begin
      ent_alloc             = '0;
      ent_alloc.prev_line   = line_ff;
      ent_alloc.first_line  = line_ff;

      ent_new    = ent_q;
      raised     = {2'b0, quo} + (ptt_pkg::CRIT_W+2)'(ent_q.crit_conf) + 1'b1;
      reuse_span = (ptt_pkg::DIST_W+1)'(ent_q.dist_cnt) +
                   (ptt_pkg::DIST_W+1)'(ent_q.wait_ctr);
      critical   = ent_q.crit_conf >= thr_ff;
      gate       = (ent_q.reuse_conf != '0) || !pdyn_ff || !pen_ff;

      act_in  = act_ff;
      trig_in = trig_ff;
      tgt_in  = tgt_ff;
      miss_in = miss_ff;

      if (cmd.load) begin
         act_in  = ptt_pkg::ACT_NONE;
         trig_in = '0;
         tgt_in  = '0;
         miss_in = (req_func == ptt_pkg::FUNC_ACCESS) && !req_hit;
      end

      if (func_ff == ptt_pkg::FUNC_REFILL) begin
         if (mode_ff == '0) begin
            ent_new.crit_conf = cmax_ff;
         end else if (crit_ff > limit_ff) begin
            ent_new.crit_conf = (raised > (ptt_pkg::CRIT_W+2)'(cmax_ff)) ?
                                cmax_ff : raised[ptt_pkg::CONF_W-1:0];
         end else if (ent_q.crit_conf != '0) begin
            ent_new.crit_conf = ent_q.crit_conf - 1'b1;
         end
      end else if (line_ff != ent_q.prev_line) begin
         if (cmd.update && gate) begin
            act_in  = !critical ? ptt_pkg::ACT_LOOKUP :
                      (hit_ff ? ptt_pkg::ACT_SAMPLE : ptt_pkg::ACT_INSERT);
            trig_in = ent_q.prev_line;
            tgt_in  = line_ff;
         end
         ent_new.prev_line = line_ff;
         if (ent_q.second_line == '0) begin
            ent_new.second_line = line_ff;
         end else if (line_ff == ent_q.first_line) begin
            ent_new.wait_ctr = ptt_pkg::WAIT_W'(1);
         end else if ((ent_q.wait_ctr != '0) && (line_ff == ent_q.second_line)) begin
            if ((reuse_span > ptt_pkg::REUSE_LIMIT) &&
                (ent_q.reuse_conf < ptt_pkg::REUSE_CONF_MAX)) begin
               ent_new.reuse_conf = ent_q.reuse_conf + 1'b1;
            end
            ent_new.first_line  = line_ff;
            ent_new.second_line = '0;
            ent_new.dist_cnt    = '0;
            ent_new.wait_ctr    = '0;
         end else if ((ent_q.wait_ctr >= ptt_pkg::WAIT_TIMEOUT) ||
                      ((ent_q.wait_ctr == '0) &&
                       (ent_q.dist_cnt >= ptt_pkg::DIST_TIMEOUT))) begin
            if (ent_q.reuse_conf != '0) begin
               ent_new.reuse_conf = ent_q.reuse_conf - 1'b1;
            end
            ent_new.first_line  = line_ff;
            ent_new.second_line = '0;
            ent_new.dist_cnt    = '0;
            ent_new.wait_ctr    = '0;
         end else if (ent_q.wait_ctr != '0) begin
            ent_new.wait_ctr = ent_q.wait_ctr + 1'b1;
         end else begin
            ent_new.dist_cnt = ent_q.dist_cnt + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      trig_ff <= trig_in;
      tgt_ff  <= tgt_in;
      miss_ff <= miss_in;
      if (cmd.emit) begin
         rsp_ff <= {1'b0, miss_ff, tgt_ff, trig_ff, act_ff};
      end
   end

   assign rsp_data      = rsp_ff;
   assign sts.match     = match_ff;
   assign sts.is_access = func_ff;
   assign sts.full      = full;
   assign sts.div_busy  = div_busy;

endmodule

### hw/rtl/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: table search, division, entry update, rank pass, allocation and result hand-off.
// ----------------------------------------------------------------------------
module ptt_ctrl #(
   parameter int TABLE_ENTRIES = ptt_pkg::TABLE_ENTRIES_DEF,
   parameter int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  ptt_pkg::sts_type  sts,
   output ptt_pkg::cmd_type  cmd,
   output logic [AW-1:0]     addr
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_READ_ENT,
      ST_UPDATE,
      ST_RANK,
      ST_RANK_END,
      ST_ALLOC,
      ST_DONE
   } state_type;

   state_type      state_ff, state_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           last;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      last         = idx_ff == AW'(TABLE_ENTRIES - 1);
      cmd          = '0;
      cmd.phase    = ptt_pkg::PH_SCAN;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN, ST_RANK: begin
            cmd.rd    = 1'b1;
            cmd.phase = (state_ff == ST_RANK) ? ptt_pkg::PH_RANK : ptt_pkg::PH_SCAN;
            idx_in    = idx_ff + 1'b1;
            if (last) begin
               idx_in   = '0;
               state_in = (state_ff == ST_RANK) ? ST_RANK_END : ST_SCAN_END;
            end
         end
         ST_SCAN_END: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (sts.match) begin
               state_in = sts.is_access ? ST_READ_ENT : ST_DIV_START;
            end else if (sts.is_access) begin
               state_in = ST_DONE;
            end else begin
               state_in = sts.full ? ST_RANK : ST_ALLOC;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_READ_ENT;
            end
         end
         ST_READ_ENT: begin
            cmd.rd        = 1'b1;
            cmd.sel_match = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DONE;
         end
         ST_RANK_END: state_in = ST_ALLOC;
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign addr       = idx_ff;

endmodule
